// ===== sv/assert_macros.svh =====
// Assertion macros used by the filter table RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DAFILT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("filter table assertion failed");

// Next-cycle implication.
`define DAFILT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("filter table assertion failed");

`endif

// ===== sv/dafilt_pkg.sv =====
// Types and constants of the device address filter table.
// Used by dafilt_cell and device_address_filter_table.
package dafilt_pkg;

    localparam int ADDR_W = 48;
    localparam int CMD_W  = 3;
    localparam int IDX_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_ENABLE  = 3'd3,
        CMD_DISABLE = 3'd4,
        CMD_MATCH   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        t_cmd              op;
        logic [ADDR_W-1:0] addr;
        logic              rnd;
        logic              clr;
        logic              ena;
        logic              dis;
    } t_cell_bus;

    // Per-cell status back to the controller and the next cell.
    typedef struct packed {
        logic tok;
        logic hit;
        logic pass;
    } t_cell_stat;

endpackage

// ===== sv/dafilt_cell.sv =====
// One slot of the filter table: address, type, in-use and enable bits,
// plus the search token stage. Depends on dafilt_pkg.
module dafilt_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dafilt_pkg::t_cell_bus  i_bus,
    input  logic                   i_tok,
    output dafilt_pkg::t_cell_stat o_stat
);
    import dafilt_pkg::*;

    logic              r_tok;
    logic              r_used;
    logic              r_en;
    logic              r_rnd;
    logic [ADDR_W-1:0] r_addr;

    logic              n_used;
    logic              n_en;
    logic              n_rnd;
    logic              w_eq;
    logic              w_hit;
    logic              w_wr;

    assign w_eq = (r_addr == i_bus.addr) && (r_rnd == i_bus.rnd);

    always_comb begin
        case (i_bus.op)
            CMD_ADD:    w_hit = r_tok && !r_used;
            CMD_REMOVE: w_hit = r_tok && r_used && w_eq;
            CMD_MATCH:  w_hit = r_tok && r_used && r_en && w_eq;
            default:    w_hit = 1'b0;
        endcase
    end

    assign w_wr = w_hit && (i_bus.op == CMD_ADD);

    always_comb begin
        n_used = r_used;
        n_en   = r_en;
        n_rnd  = r_rnd;
        if (i_bus.clr) begin
            n_used = 1'b0;
            n_en   = 1'b0;
            n_rnd  = 1'b0;
        end else if (i_bus.ena) begin
            n_en = r_en | r_used;
        end else if (i_bus.dis) begin
            n_en = 1'b0;
        end else if (w_hit) begin
            case (i_bus.op)
                CMD_ADD: begin
                    n_used = 1'b1;
                    n_rnd  = i_bus.rnd;
                end
                CMD_REMOVE: begin
                    n_used = 1'b0;
                    n_en   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_used <= 1'b0;
            r_en   <= 1'b0;
            r_rnd  <= 1'b0;
        end else begin
            r_tok  <= i_tok;
            r_used <= n_used;
            r_en   <= n_en;
            r_rnd  <= n_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_addr <= i_bus.addr;
        end
    end

    // Absorb the token on a hit, hand it on otherwise.
    assign o_stat.tok  = r_tok;
    assign o_stat.hit  = w_hit;
    assign o_stat.pass = r_tok && !w_hit;

endmodule

// ===== sv/device_address_filter_table.sv =====
// Device address filter table: a chain of slot cells and its controller.
// Depends on dafilt_pkg, dafilt_cell and assert_macros.svh.
//
// Use: the input channel (i_in_valid / o_in_ready) carries one command item
// with an address and a type bit; the output channel (o_out_valid /
// i_out_ready) returns one result item per command: status, matched and
// match_index.
// Clear, enable and disable act on all cells at acceptance; unused codes act
// on none. These items go through ST_DONE into the output register. Add,
// remove and match send a search token down the chain of ENTRIES cells, one
// cell per cycle, and stop at the first cell that hits; the result is
// captured when the walk ends and goes through ST_DONE into the output
// register. One item is worked on at a time: no new item is accepted until
// its result has been loaded into the output register.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver stalls, the following result holds in the
// controller and no further item is accepted until the register frees.
// Reset empties the table (all in-use, enable and type bits cleared) and
// drops any item in flight.
module device_address_filter_table #(
    parameter int ENTRIES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dafilt_pkg::CMD_W-1:0]  i_command,
    input  logic [dafilt_pkg::ADDR_W-1:0] i_device_address,
    input  logic                          i_address_is_random,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_status,
    output logic                          o_matched,
    output logic [dafilt_pkg::IDX_W-1:0]  o_match_index
);
    import dafilt_pkg::*;
    `include "assert_macros.svh"

    t_state            r_state;
    t_state            n_state;
    t_cmd              r_op;
    logic [ADDR_W-1:0] r_addr;
    logic              r_rnd;
    logic              r_res_status;
    logic              r_res_matched;
    logic [IDX_W-1:0]  r_res_idx;
    logic              r_out_valid;
    logic              r_o_status;
    logic              r_o_matched;
    logic [IDX_W-1:0]  r_o_idx;

    t_cmd              w_cmd;
    logic              w_accept;
    logic              w_is_walk;
    logic              w_start;
    logic              w_out_free;
    logic              w_load_out;
    logic              w_found;
    logic              w_walk_end;
    logic [IDX_W-1:0]  w_hit_idx;
    logic [ENTRIES-1:0] w_tok;
    logic [ENTRIES-1:0] w_hit;
    t_cell_bus         w_bus;
    t_cell_stat        w_stat [ENTRIES];

    assign w_cmd      = t_cmd'(i_command);
    assign w_is_walk  = (w_cmd == CMD_ADD) || (w_cmd == CMD_REMOVE) || (w_cmd == CMD_MATCH);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_is_walk ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                if (w_walk_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        w_accept   = i_in_valid && o_in_ready;
        w_start    = w_accept && w_is_walk;
        w_load_out = (r_state == ST_DONE) && w_out_free;
        w_bus.op   = r_op;
        w_bus.addr = r_addr;
        w_bus.rnd  = r_rnd;
        w_bus.clr  = w_accept && (w_cmd == CMD_CLEAR);
        w_bus.ena  = w_accept && (w_cmd == CMD_ENABLE);
        w_bus.dis  = w_accept && (w_cmd == CMD_DISABLE);
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            logic w_tok_in;
            if (g == 0) begin : g_head
                assign w_tok_in = w_start;
            end else begin : g_link
                assign w_tok_in = w_stat[g-1].pass;
            end
            dafilt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_bus   (w_bus),
                .i_tok   (w_tok_in),
                .o_stat  (w_stat[g])
            );
            assign w_tok[g] = w_stat[g].tok;
            assign w_hit[g] = w_stat[g].hit;
        end
    endgenerate

    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_hit[i]) begin
                w_hit_idx = w_hit_idx | IDX_W'(i);
            end
        end
    end

    assign w_found    = |w_hit;
    assign w_walk_end = w_found || w_stat[ENTRIES-1].pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op          <= w_cmd;
            r_addr        <= i_device_address;
            r_rnd         <= i_address_is_random;
            r_res_status  <= 1'b0;
            r_res_matched <= 1'b0;
            r_res_idx     <= '0;
        end else if ((r_state == ST_WALK) && w_walk_end) begin
            r_res_status  <= (r_op == CMD_ADD) && !w_found;
            r_res_matched <= (r_op == CMD_MATCH) && w_found;
            r_res_idx     <= (r_op == CMD_MATCH) ? w_hit_idx : '0;
        end
        if (w_load_out) begin
            r_o_status  <= r_res_status;
            r_o_matched <= r_res_matched;
            r_o_idx     <= r_res_idx;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_matched     = r_o_matched;
    assign o_match_index = r_o_idx;

    `DAFILT_ASSERT_IMP(a_tok_single, 1'b1, $onehot0(w_tok))
    `DAFILT_ASSERT_IMP(a_tok_only_walk, r_state != ST_WALK, w_tok == '0)
    `DAFILT_ASSERT_IMP(a_hit_single, 1'b1, $onehot0(w_hit))
    `DAFILT_ASSERT_NXT(a_start_head, w_start, w_tok[0] && (r_state == ST_WALK))

endmodule
